// ===== rtl/core/vlb_pkg.sv =====
`timescale 1ns / 1ps

package vlb_pkg;

    // Pipeline depth: operand products, numerator, one stage per quotient bit, then the merge register
    localparam int DIV_STEPS   = 8;
    localparam int LANE_STAGES = DIV_STEPS + 2;
    localparam int PIPE_DEPTH  = LANE_STAGES + 1;

    // Channel mode codes
    localparam logic [1:0] MODE_ONE   = 2'd0;
    localparam logic [1:0] MODE_THREE = 2'd1;
    localparam logic [1:0] MODE_FOUR  = 2'd2;
    localparam logic [1:0] CHANNEL_MODE_RESET = MODE_FOUR;

    // Register indexes
    localparam logic REG_CHANNEL_MODE = 1'b0;

    // Pixel constants
    localparam logic [7:0] PIX_MAX    = 8'd255;
    localparam logic [7:0] BLEND_HALF = 8'd128;

    typedef struct packed {
        logic [7:0] base_red;
        logic [7:0] base_green;
        logic [7:0] base_blue;
        logic [7:0] base_alpha;
        logic [7:0] blend_red;
        logic [7:0] blend_green;
        logic [7:0] blend_blue;
        logic       last_pixel;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] out_alpha;
        logic       out_last;
    } out_beat_t;

    // Per-stage load enables shared by all lanes
    typedef struct packed {
        logic [LANE_STAGES-1:0] load;
    } stage_load_t;

endpackage

// ===== rtl/core/vlb_lane.sv =====
`timescale 1ns / 1ps

module vlb_lane (
    input  logic                aclk,
    input  vlb_pkg::stage_load_t stage_load,
    input  logic [7:0]          base,
    input  logic [7:0]          blend,
    output logic [7:0]          result
);
    import vlb_pkg::*;

    // ---------------- stage 0: products and divisor ----------------
    logic        hi_c;
    logic [7:0]  inv_c;
    logic [7:0]  den_c;
    logic [7:0]  mul_b_c;
    logic [7:0]  dark_c;
    logic        fen_c;
    logic [7:0]  fval_c;

    logic [15:0] p1_reg;
    logic [15:0] p2_reg;
    logic        hi_reg;
    logic [7:0]  den0_reg;
    logic        fen0_reg;
    logic [7:0]  fval0_reg;

    always_comb begin
        hi_c    = (blend >= BLEND_HALF);
        inv_c   = PIX_MAX - blend;
        den_c   = hi_c ? {inv_c[6:0], 1'b0}   // 2*(255-b), b >= 128
                       : {blend[6:0], 1'b0};  // 2*b, b < 128
        mul_b_c = hi_c ? PIX_MAX : blend;
        dark_c  = PIX_MAX - {blend[6:0], 1'b0};
        // blend at the rails has no finite quotient
        fen_c   = (blend == 8'd0) || (blend == PIX_MAX);
        if (blend == 8'd0) begin
            fval_c = (base == PIX_MAX) ? PIX_MAX : 8'd0;
        end else begin
            fval_c = (base == 8'd0) ? 8'd0 : PIX_MAX;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_load.load[0]) begin
            p1_reg    <= 16'(base) * 16'(mul_b_c);
            p2_reg    <= hi_c ? 16'd0 : 16'(PIX_MAX - base) * 16'(dark_c);
            hi_reg    <= hi_c;
            den0_reg  <= den_c;
            fen0_reg  <= fen_c;
            fval0_reg <= fval_c;
        end
    end

    // ---------------- stage 1: numerator, clamp detection ----------------
    logic [16:0] twice_c;
    logic [16:0] num17_c;
    logic [15:0] num_c;
    logic        neg_c;
    logic        sat_c;
    logic        fen1_c;
    logic [7:0]  fval1_c;

    logic [7:0] rem_reg  [0:DIV_STEPS];
    logic [7:0] low_reg  [0:DIV_STEPS];
    logic [7:0] quo_reg  [0:DIV_STEPS];
    logic [7:0] den_reg  [0:DIV_STEPS];
    logic       fen_reg  [0:DIV_STEPS];
    logic [7:0] fval_reg [0:DIV_STEPS];

    always_comb begin
        twice_c = {p1_reg, 1'b0};
        num17_c = hi_reg ? {1'b0, p1_reg} : (twice_c - {1'b0, p2_reg});
        neg_c   = !hi_reg && (twice_c < {1'b0, p2_reg});
        num_c   = num17_c[15:0];
        sat_c   = (num_c >= {den0_reg, 8'h00});
        fen1_c  = fen0_reg || neg_c || sat_c;
        if (fen0_reg) begin
            fval1_c = fval0_reg;
        end else if (neg_c) begin
            fval1_c = 8'd0;
        end else begin
            fval1_c = PIX_MAX;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_load.load[1]) begin
            rem_reg[0]  <= num_c[15:8];
            low_reg[0]  <= num_c[7:0];
            quo_reg[0]  <= 8'd0;
            den_reg[0]  <= den0_reg;
            fen_reg[0]  <= fen1_c;
            fval_reg[0] <= fval1_c;
        end
    end

    // ---------------- stages 2..: restoring divide, one bit each ----------------
    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
        logic [8:0] trial;
        logic       take;

        assign trial = {rem_reg[j], low_reg[j][7]};
        assign take  = (trial >= {1'b0, den_reg[j]});

        always_ff @(posedge aclk) begin
            if (stage_load.load[j+2]) begin
                rem_reg[j+1]  <= take ? 8'(trial - {1'b0, den_reg[j]}) : trial[7:0];
                low_reg[j+1]  <= {low_reg[j][6:0], 1'b0};
                quo_reg[j+1]  <= {quo_reg[j][6:0], take};
                den_reg[j+1]  <= den_reg[j];
                fen_reg[j+1]  <= fen_reg[j];
                fval_reg[j+1] <= fval_reg[j];
            end
        end
    end

    assign result = fen_reg[DIV_STEPS] ? fval_reg[DIV_STEPS] : quo_reg[DIV_STEPS];

endmodule

// ===== rtl/core/vlb_merge.sv =====
`timescale 1ns / 1ps

module vlb_merge (
    input  logic               aclk,
    input  logic               load,
    input  logic [1:0]         channel_mode,
    input  logic [7:0]         red,
    input  logic [7:0]         green,
    input  logic [7:0]         blue,
    input  logic [7:0]         alpha,
    input  logic               last,
    output vlb_pkg::out_beat_t beat
);
    import vlb_pkg::*;

    out_beat_t beat_next;
    out_beat_t beat_reg;

    // Gate lanes by channel mode
    always_comb begin
        beat_next.out_red  = red;
        beat_next.out_last = last;
        case (channel_mode)
            MODE_ONE: begin
                beat_next.out_green = 8'd0;
                beat_next.out_blue  = 8'd0;
                beat_next.out_alpha = 8'd0;
            end
            MODE_THREE: begin
                beat_next.out_green = green;
                beat_next.out_blue  = blue;
                beat_next.out_alpha = 8'd0;
            end
            default: begin
                beat_next.out_green = green;
                beat_next.out_blue  = blue;
                beat_next.out_alpha = alpha;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            beat_reg <= beat_next;
        end
    end

    assign beat = beat_reg;

endmodule

// ===== rtl/core/vivid_light_blend.sv =====
`timescale 1ns / 1ps

// Vivid-light blend of a base pixel with a blend pixel, per color channel.
// Input channel (s_valid/s_ready/s_data): one pixel pair per beat.
// Output channel (m_valid/m_ready/m_data): one blended pixel per beat, in order,
// with out_last copied from last_pixel.
// APB port: register 0 at address 0 is channel_mode (0 red only, 1 RGB,
// 2 or 3 RGB plus base alpha). Write it only while the stream is idle.
// Three channel lanes each run two operand stages and an 8-stage restoring
// divider, one quotient bit per stage, then a merge register applies the
// channel mode.
// Throughput: one beat per cycle sustained while m_ready stays high.
// Stalls: every stage holds its own valid bit, so bubbles close up behind a
// stalled output; s_ready drops only when all 11 stages are full and m_ready
// is low.
// Reset (aresetn low, synchronous): pipeline emptied, channel_mode back to 2.

module vivid_light_blend (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  vlb_pkg::in_beat_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output vlb_pkg::out_beat_t m_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import vlb_pkg::*;

    // ---------------- configuration register ----------------
    logic [1:0] channel_mode_reg;
    logic       cfg_wr;
    logic       cfg_idx;

    assign cfg_idx = paddr[2];
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            channel_mode_reg <= CHANNEL_MODE_RESET;
        end else if (cfg_wr && (cfg_idx == REG_CHANNEL_MODE)) begin
            channel_mode_reg <= pwdata[1:0];
        end
    end

    assign prdata = (cfg_idx == REG_CHANNEL_MODE) ? {30'd0, channel_mode_reg} : 32'd0;

    // ---------------- per-stage valid and ready chain ----------------
    logic [PIPE_DEPTH-1:0] vld_reg;
    logic [PIPE_DEPTH-1:0] vld_next;
    logic [PIPE_DEPTH-1:0] rdy;

    always_comb begin
        rdy[PIPE_DEPTH-1] = !vld_reg[PIPE_DEPTH-1] || m_ready;
        for (int k = PIPE_DEPTH - 2; k >= 0; k--) begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
        vld_next[0] = rdy[0] ? s_valid : vld_reg[0];
        for (int k = 1; k < PIPE_DEPTH; k++) begin
            vld_next[k] = rdy[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign s_ready = rdy[0];
    assign m_valid = vld_reg[PIPE_DEPTH-1];

    stage_load_t stage_load;
    assign stage_load.load = rdy[LANE_STAGES-1:0];

    // ---------------- alpha and last alongside the lanes ----------------
    logic [7:0] alpha_reg [0:LANE_STAGES-1];
    logic       last_reg  [0:LANE_STAGES-1];

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            alpha_reg[0] <= s_data.base_alpha;
            last_reg[0]  <= s_data.last_pixel;
        end
    end

    for (genvar k = 1; k < LANE_STAGES; k++) begin : g_side
        always_ff @(posedge aclk) begin
            if (rdy[k]) begin
                alpha_reg[k] <= alpha_reg[k-1];
                last_reg[k]  <= last_reg[k-1];
            end
        end
    end

    // ---------------- channel lanes ----------------
    logic [7:0] red_res;
    logic [7:0] green_res;
    logic [7:0] blue_res;

    vlb_lane u_lane_red (
        .aclk       (aclk),
        .stage_load (stage_load),
        .base       (s_data.base_red),
        .blend      (s_data.blend_red),
        .result     (red_res)
    );

    vlb_lane u_lane_green (
        .aclk       (aclk),
        .stage_load (stage_load),
        .base       (s_data.base_green),
        .blend      (s_data.blend_green),
        .result     (green_res)
    );

    vlb_lane u_lane_blue (
        .aclk       (aclk),
        .stage_load (stage_load),
        .base       (s_data.base_blue),
        .blend      (s_data.blend_blue),
        .result     (blue_res)
    );

    // ---------------- merge into output register ----------------
    vlb_merge u_merge (
        .aclk         (aclk),
        .load         (rdy[PIPE_DEPTH-1]),
        .channel_mode (channel_mode_reg),
        .red          (red_res),
        .green        (green_res),
        .blue         (blue_res),
        .alpha        (alpha_reg[LANE_STAGES-1]),
        .last         (last_reg[LANE_STAGES-1]),
        .beat         (m_data)
    );

endmodule

// ===== rtl/core/vlb_check.sv =====
`timescale 1ns / 1ps

module vlb_check (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input vlb_pkg::out_beat_t m_data
);
    import vlb_pkg::*;

    localparam int CNT_W = $clog2(PIPE_DEPTH + 1);

    // Beats accepted but not yet delivered
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    always_comb begin
        cnt_next = cnt_reg + CNT_W'(s_valid && s_ready) - CNT_W'(m_valid && m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("output beat changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid right after reset");

    a_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(PIPE_DEPTH))
        else $error("more beats in flight than pipeline stages");

    a_no_phantom: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> cnt_reg != '0)
        else $error("output beat with nothing accepted");

    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == CNT_W'(PIPE_DEPTH)) && !m_ready |-> !s_ready)
        else $error("input accepted into a full stalled pipeline");

endmodule

bind vivid_light_blend vlb_check u_vlb_check (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
